/* src/nwm_pkg.sv */
package nwm_pkg;

  localparam int NODE_W          = 6;
  localparam int SYM_W           = 7;
  localparam int DEF_MAX_STATES  = 63;
  localparam int DEF_SYMBOL_BITS = 128;
  localparam int WORDS_PER_SLOT  = 4;
  localparam int SYM_EMPTY       = 0;
  localparam int SYM_LOOKAHEAD   = 3;
  localparam logic [SYM_W-1:0] SYM_TAB     = 7'd4;
  localparam logic [7:0]       PRINT_SHIFT = 8'd27;
  localparam logic [7:0]       CHAR_TAB    = 8'h09;
  localparam logic [7:0]       CHAR_LOW    = 8'h20;
  localparam logic [7:0]       CHAR_HIGH   = 8'h7e;

  localparam logic [2:0] REQ_LOAD_SYM = 3'd0;
  localparam logic [2:0] REQ_LOAD_MOT = 3'd1;
  localparam logic [2:0] REQ_START    = 3'd2;
  localparam logic [2:0] REQ_BYTE     = 3'd3;
  localparam logic [2:0] REQ_END      = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MATCH   = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;
  localparam logic [1:0] ST_BAD     = 2'd3;

  localparam logic CFG_IDX_STATE_COUNT = 1'b0;

  typedef struct packed {
    logic              we_sym;
    logic              we_mot;
    logic [NODE_W-1:0] node;
    logic              slot;
    logic [1:0]        widx;
    logic [31:0]       bits;
    logic [6:0]        motion;
    logic              second;
  } tbl_wr_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              slot;
    logic [1:0]        widx;
  } tbl_rd_t;

  typedef struct packed {
    logic              ok;
    logic [NODE_W-1:0] node;
  } tgt_res_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              k;
    logic              alive;
    logic              second;
  } frame_t;

endpackage

/* src/nwm_tables.sv */
module nwm_tables #(
  parameter int MAX_STATES = 63
) (
  input  logic             clk,
  input  nwm_pkg::tbl_wr_t wr,
  input  nwm_pkg::tbl_rd_t rd,
  output logic [31:0]      sym_word,
  output logic [6:0]       motion,
  output logic             second
);
  import nwm_pkg::*;

  localparam int SYM_DEPTH = MAX_STATES * 2 * WORDS_PER_SLOT;
  localparam int MOT_DEPTH = MAX_STATES * 2;
  localparam int SA_W = $clog2(SYM_DEPTH);
  localparam int MA_W = $clog2(MOT_DEPTH);
  localparam int FA_W = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;

  logic [31:0] sym_mem [SYM_DEPTH];
  logic [6:0]  mot_mem [MOT_DEPTH];
  logic        sec_mem [MAX_STATES];

  logic [SA_W-1:0] sym_wa, sym_ra;
  logic [MA_W-1:0] mot_wa, mot_ra;
  logic [FA_W-1:0] sec_wa, sec_ra;

  assign sym_wa = SA_W'({wr.node, wr.slot, wr.widx});
  assign sym_ra = SA_W'({rd.node, rd.slot, rd.widx});
  assign mot_wa = MA_W'({wr.node, wr.slot});
  assign mot_ra = MA_W'({rd.node, rd.slot});
  assign sec_wa = FA_W'(wr.node);
  assign sec_ra = FA_W'(rd.node);

  always_ff @(posedge clk) begin
    if (wr.we_sym) begin
      sym_mem[sym_wa] <= wr.bits;
    end
    sym_word <= sym_mem[sym_ra];
  end

  always_ff @(posedge clk) begin
    if (wr.we_mot) begin
      mot_mem[mot_wa] <= wr.motion;
      sec_mem[sec_wa] <= wr.second;
    end
    motion <= mot_mem[mot_ra];
    second <= sec_mem[sec_ra];
  end

endmodule

/* src/nwm_target_unit.sv */
module nwm_target_unit (
  input  logic [nwm_pkg::NODE_W-1:0] node,
  input  logic [6:0]                 motion,
  input  logic [nwm_pkg::NODE_W-1:0] n,
  output nwm_pkg::tgt_res_t          res
);
  import nwm_pkg::*;

  logic signed [7:0] dest;

  // Target is node plus the signed motion; it must land in 0..n.
  assign dest     = $signed({2'b00, node}) + $signed({motion[6], motion});
  assign res.ok   = !dest[7] && (dest[6:0] <= {1'b0, n});
  assign res.node = dest[NODE_W-1:0];

endmodule

/* src/nfa_whole_string_matcher.sv */
// Load and start words go straight to the done state; so do a bad byte and a word after the verdict.
// A byte walks each node at most once: enter, then per slot two reads and an evaluation,
// then close, pop when a parent is open, and return; a link to a node already walked is an
// enter and a return, and the scan steps over every node. End restarts the walk from every
// active node, so a node may be walked once per active root. One word at a time.
// Reset (synchronous, rst_n low): active set holds node 0, verdict running, state_count 1.
module nfa_whole_string_matcher #(
  parameter int MAX_STATES  = nwm_pkg::DEF_MAX_STATES,
  parameter int SYMBOL_BITS = nwm_pkg::DEF_SYMBOL_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: node_index[5:0], slot[6], word_index[8:7], word_bits[40:9],
  //        motion[47:41], has_second[48], char_code[56:49], zero fill
  input  logic [63:0] in_tdata,
  // tuser: req_type[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: status[1:0], zero fill
  output logic [7:0]  out_tdata,
  // tuser: done_res[0]
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import nwm_pkg::*;

  // Sets carry one bit per node plus one for the accepting node.
  localparam int SET_W = MAX_STATES + 1;
  localparam int SI_W  = $clog2(SET_W);
  localparam int DP_W  = $clog2(MAX_STATES + 1);
  localparam int ST_W  = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SCAN  = 10'b0000000010,
    S_ENTER = 10'b0000000100,
    S_RD0   = 10'b0000001000,
    S_RD1   = 10'b0000010000,
    S_EVAL  = 10'b0000100000,
    S_NEND  = 10'b0001000000,
    S_POP   = 10'b0010000000,
    S_RET   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  // Input word fields.
  logic [NODE_W-1:0] f_node;
  logic              f_slot;
  logic [1:0]        f_widx;
  logic [31:0]       f_bits;
  logic [6:0]        f_motion;
  logic              f_second;
  logic [7:0]        f_char;

  assign f_node   = in_tdata[5:0];
  assign f_slot   = in_tdata[6];
  assign f_widx   = in_tdata[8:7];
  assign f_bits   = in_tdata[40:9];
  assign f_motion = in_tdata[47:41];
  assign f_second = in_tdata[48];
  assign f_char   = in_tdata[56:49];

  state_t            state_r, state_nxt;
  logic [2:0]        req_r, req_nxt;
  logic [NODE_W-1:0] sc_r;
  logic [1:0]        verdict_r, verdict_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic              mode_end_r, mode_end_nxt;
  logic [SET_W-1:0]  active_r, active_nxt;
  logic [SET_W-1:0]  next_r, next_nxt;
  logic [SET_W-1:0]  visited_r, visited_nxt;
  logic [SET_W-1:0]  settled_r, settled_nxt;
  logic [SET_W-1:0]  memo_r, memo_nxt;
  logic [NODE_W-1:0] s_r, s_nxt;
  logic              any_alive_r, any_alive_nxt;
  logic              match_r, match_nxt;
  frame_t            cur_r, cur_nxt;
  logic [NODE_W-1:0] call_r, call_nxt;
  logic              ret_r, ret_nxt;
  logic [DP_W-1:0]   depth_r, depth_nxt;
  logic              w0_empty_r, w0_empty_nxt;
  logic              w0_look_r, w0_look_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic              out_done_r, out_done_nxt;

  logic [NODE_W-1:0] n;
  logic              accept;
  tbl_wr_t           tw;
  tbl_rd_t           tr;
  logic [31:0]       sym_word;
  logic [6:0]        tbl_motion;
  logic              tbl_second;
  tgt_res_t          tgt;

  // Walk stack of open parent frames; the innermost frame lives in cur_r.
  frame_t          stack_mem [MAX_STATES];
  logic            stk_we;
  logic [ST_W-1:0] stk_wa, stk_ra;
  frame_t          stk_rd_r;

  assign n = (int'(sc_r) > MAX_STATES) ? NODE_W'(MAX_STATES) : sc_r;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Table loads are written straight from the accepted word.
  always_comb begin
    tw.node   = f_node;
    tw.slot   = f_slot;
    tw.widx   = f_widx;
    tw.bits   = f_bits;
    tw.motion = f_motion;
    tw.second = f_second;
    tw.we_sym = accept && (in_tuser == REQ_LOAD_SYM) && (int'(f_node) < MAX_STATES)
                && ((int'(f_widx) * 32) < SYMBOL_BITS);
    tw.we_mot = accept && (in_tuser == REQ_LOAD_MOT) && (int'(f_node) < MAX_STATES);
  end

  // The first read of a slot fetches word 0 (empty and lookahead marks),
  // the second fetches the word that holds the current symbol.
  always_comb begin
    tr.node = cur_r.node;
    tr.slot = cur_r.k;
    tr.widx = (state_r == S_RD1) ? sym_r[6:5] : 2'd0;
  end

  nwm_tables #(.MAX_STATES(MAX_STATES)) u_tables (
    .clk      (clk),
    .wr       (tw),
    .rd       (tr),
    .sym_word (sym_word),
    .motion   (tbl_motion),
    .second   (tbl_second)
  );

  nwm_target_unit u_target (
    .node   (cur_r.node),
    .motion (tbl_motion),
    .n      (n),
    .res    (tgt)
  );

  assign stk_wa = ST_W'(depth_r - DP_W'(1));
  assign stk_ra = ST_W'(depth_r - DP_W'(2));

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_wa] <= cur_r;
    end
    stk_rd_r <= stack_mem[stk_ra];
  end

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_STATE_COUNT) ? {26'd0, sc_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r <= NODE_W'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && (cfg_paddr[2] == CFG_IDX_STATE_COUNT)) begin
      sc_r <= cfg_pwdata[NODE_W-1:0];
    end
  end

  logic sym_hit;
  logic imm;
  logic imm_val;
  logic [SI_W-1:0] call_ix;
  logic [SI_W-1:0] cur_ix;

  assign sym_hit = (int'(sym_r) < SYMBOL_BITS) && sym_word[sym_r[4:0]];
  assign call_ix = call_r[SI_W-1:0];
  assign cur_ix  = cur_r.node[SI_W-1:0];

  // Immediate answer for a node about to be entered, without opening a frame.
  always_comb begin
    imm     = 1'b0;
    imm_val = 1'b0;
    if (!mode_end_r) begin
      if (call_r >= n) begin
        imm = 1'b1;
      end else if (settled_r[call_ix]) begin
        imm     = 1'b1;
        imm_val = memo_r[call_ix];
      end else if (visited_r[call_ix]) begin
        imm = 1'b1;
      end
    end else begin
      if (call_r == n) begin
        imm     = 1'b1;
        imm_val = 1'b1;
      end else if (call_r > n) begin
        imm = 1'b1;
      end else if (visited_r[call_ix]) begin
        imm = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    verdict_nxt    = verdict_r;
    sym_nxt        = sym_r;
    mode_end_nxt   = mode_end_r;
    active_nxt     = active_r;
    next_nxt       = next_r;
    visited_nxt    = visited_r;
    settled_nxt    = settled_r;
    memo_nxt       = memo_r;
    s_nxt          = s_r;
    any_alive_nxt  = any_alive_r;
    match_nxt      = match_r;
    cur_nxt        = cur_r;
    call_nxt       = call_r;
    ret_nxt        = ret_r;
    depth_nxt      = depth_r;
    w0_empty_nxt   = w0_empty_r;
    w0_look_nxt    = w0_look_r;
    out_status_nxt = out_status_r;
    out_done_nxt   = out_done_r;
    out_valid_nxt  = out_tready ? 1'b0 : out_valid_r;
    stk_we         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt   = in_tuser;
          state_nxt = S_DONE;
          unique case (in_tuser)
            REQ_START: begin
              active_nxt  = SET_W'(1);
              verdict_nxt = ST_OK;
            end
            REQ_BYTE: begin
              if (verdict_r == ST_OK) begin
                if (f_char == CHAR_TAB) begin
                  sym_nxt = SYM_TAB;
                end else begin
                  sym_nxt = SYM_W'(f_char - PRINT_SHIFT);
                end
                if ((f_char == CHAR_TAB) || ((f_char >= CHAR_LOW) && (f_char <= CHAR_HIGH)))
                begin
                  next_nxt      = '0;
                  visited_nxt   = '0;
                  settled_nxt   = '0;
                  memo_nxt      = '0;
                  any_alive_nxt = 1'b0;
                  s_nxt         = '0;
                  mode_end_nxt  = 1'b0;
                  state_nxt     = S_SCAN;
                end else begin
                  verdict_nxt = ST_BAD;
                end
              end
            end
            REQ_END: begin
              if (verdict_r == ST_OK) begin
                match_nxt    = active_r[n[SI_W-1:0]];
                visited_nxt  = '0;
                s_nxt        = '0;
                mode_end_nxt = 1'b1;
                state_nxt    = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if ((mode_end_r && match_r) || (s_r >= n)) begin
          if (mode_end_r) begin
            verdict_nxt = match_r ? ST_MATCH : ST_NOMATCH;
          end else if (any_alive_r) begin
            active_nxt = next_r;
          end else begin
            verdict_nxt = ST_NOMATCH;
          end
          state_nxt = S_DONE;
        end else if (active_r[s_r[SI_W-1:0]]) begin
          call_nxt = s_r;
          if (mode_end_r) begin
            visited_nxt = '0;
          end
          state_nxt = S_ENTER;
        end else begin
          s_nxt = s_r + NODE_W'(1);
        end
      end

      S_ENTER: begin
        if (imm) begin
          ret_nxt   = imm_val;
          state_nxt = S_RET;
        end else begin
          stk_we               = (depth_r != '0);
          visited_nxt[call_ix] = 1'b1;
          cur_nxt.node         = call_r;
          cur_nxt.k            = 1'b0;
          cur_nxt.alive        = 1'b0;
          cur_nxt.second       = 1'b0;
          depth_nxt            = depth_r + DP_W'(1);
          state_nxt            = S_RD0;
        end
      end

      S_RD0: begin
        state_nxt = S_RD1;
      end

      S_RD1: begin
        w0_empty_nxt   = sym_word[SYM_EMPTY];
        w0_look_nxt    = sym_word[SYM_LOOKAHEAD];
        cur_nxt.second = tbl_second;
        state_nxt      = S_EVAL;
      end

      S_EVAL: begin
        // Default path: go on to the next slot or close the node.
        if (!cur_r.k && cur_r.second) begin
          cur_nxt.k = 1'b1;
          state_nxt = S_RD0;
        end else begin
          state_nxt = S_NEND;
        end
        if (!mode_end_r) begin
          if (sym_hit) begin
            if (tgt.ok) begin
              next_nxt[tgt.node[SI_W-1:0]] = 1'b1;
              cur_nxt.alive                = 1'b1;
            end
          end else if (w0_empty_r) begin
            if (tgt.ok) begin
              // The frame keeps its slot while the target is walked.
              cur_nxt.k = cur_r.k;
              call_nxt  = tgt.node;
              state_nxt = S_ENTER;
            end
          end else if (w0_look_r) begin
            // A lookahead kills the node and skips its later slot.
            cur_nxt.alive = 1'b0;
            state_nxt     = S_NEND;
          end
        end else if ((w0_empty_r || w0_look_r) && tgt.ok) begin
          cur_nxt.k = cur_r.k;
          call_nxt  = tgt.node;
          state_nxt = S_ENTER;
        end
      end

      S_NEND: begin
        ret_nxt = mode_end_r ? 1'b0 : cur_r.alive;
        if (!mode_end_r) begin
          settled_nxt[cur_ix] = 1'b1;
          memo_nxt[cur_ix]    = cur_r.alive;
        end
        depth_nxt = depth_r - DP_W'(1);
        state_nxt = (depth_r > DP_W'(1)) ? S_POP : S_RET;
      end

      S_POP: begin
        cur_nxt   = stk_rd_r;
        state_nxt = S_RET;
      end

      S_RET: begin
        if (depth_r == '0) begin
          if (mode_end_r) begin
            match_nxt = ret_r;
          end else begin
            any_alive_nxt = any_alive_r | ret_r;
          end
          s_nxt     = s_r + NODE_W'(1);
          state_nxt = S_SCAN;
        end else if (mode_end_r && ret_r) begin
          // Accept found: drop every open frame.
          match_nxt = 1'b1;
          depth_nxt = '0;
          state_nxt = S_SCAN;
        end else begin
          if (ret_r) begin
            cur_nxt.alive = 1'b1;
          end
          if (!cur_r.k && cur_r.second) begin
            cur_nxt.k = 1'b1;
            state_nxt = S_RD0;
          end else begin
            state_nxt = S_NEND;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          if ((req_r >= REQ_BYTE) && (verdict_r != ST_OK)) begin
            out_status_nxt = verdict_r;
            out_done_nxt   = 1'b1;
          end else begin
            out_status_nxt = ST_OK;
            out_done_nxt   = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      verdict_r   <= ST_OK;
      active_r    <= SET_W'(1);
      next_r      <= '0;
      visited_r   <= '0;
      settled_r   <= '0;
      memo_r      <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      verdict_r   <= verdict_nxt;
      active_r    <= active_nxt;
      next_r      <= next_nxt;
      visited_r   <= visited_nxt;
      settled_r   <= settled_nxt;
      memo_r      <= memo_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    sym_r        <= sym_nxt;
    mode_end_r   <= mode_end_nxt;
    s_r          <= s_nxt;
    any_alive_r  <= any_alive_nxt;
    match_r      <= match_nxt;
    cur_r        <= cur_nxt;
    call_r       <= call_nxt;
    ret_r        <= ret_nxt;
    w0_empty_r   <= w0_empty_nxt;
    w0_look_r    <= w0_look_nxt;
    out_status_r <= out_status_nxt;
    out_done_r   <= out_done_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_status_r};
  assign out_tuser  = out_done_r;

  // The walk never holds more open frames than there are nodes.
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(depth_r) <= MAX_STATES)
    else $error("walk depth exceeds node count");

  // Between root walks no frame may stay open.
  a_depth_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) || (state_r == S_SCAN)) && $past(state_r) != S_RET
    |-> depth_r == '0)
    else $error("open frames left outside a walk");

  // A node can only be settled after it was visited in this byte's walk.
  a_settled_visited: assert property (@(posedge clk) disable iff (!rst_n)
    !mode_end_r |-> (settled_r & ~visited_r) == '0)
    else $error("settled node was never visited");

endmodule
